FILE: hw/rtl/control_line_splitter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the control line splitter
// Shorthands for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CONTROL_LINE_SPLITTER_ASSERT_SVH
`define CONTROL_LINE_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Types and constants shared by the control line splitter modules.
// ----------------------------------------------------------------------------
package cls_pkg;

	localparam int WIN_DEPTH = 7;
	localparam int FILL_W    = 3;

	localparam logic [7:0] CHAR_CTL = 8'h01;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;

	localparam logic [8*WIN_DEPTH-1:0] SEEN_BY = "SEEN-BY";

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_DEPTH - 1);

	typedef struct packed {
		logic push;
		logic pop;
	} cls_win_cmd_t;

	typedef struct packed {
		logic [7:0]        head;
		logic [FILL_W-1:0] fill;
		logic              six_match;
		logic              tail_y;
	} cls_win_stat_t;

	typedef struct packed {
		logic       emit;
		logic       consume;
		logic [7:0] data;
		logic       to_ctl;
		logic       nxt_ctl;
		logic       nxt_start;
	} cls_step_t;

	typedef struct packed {
		logic [7:0] data;
		logic       to_ctl;
		logic       endm;
	} cls_res_t;

endpackage

FILE: hw/rtl/cls_window.sv
// ----------------------------------------------------------------------------
// cls_window
// Seven-byte lookahead window with fill count and pattern compare.
// ----------------------------------------------------------------------------
module cls_window
	import cls_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cls_win_cmd_t  cmd,
	input  logic [7:0]    data,
	output cls_win_stat_t stat
);

	logic [7:0]        win_q [WIN_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] wr_idx;
	logic              six_eq;

	assign wr_idx = cmd.pop ? fill_q - FILL_W'(1) : fill_q;

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end
		if (cmd.push) begin
			win_q[wr_idx] <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.push && !cmd.pop) begin
			fill_q <= fill_q + FILL_W'(1);
		end else if (cmd.pop && !cmd.push) begin
			fill_q <= fill_q - FILL_W'(1);
		end
	end

	always_comb begin
		six_eq = 1'b1;
		for (int i = 0; i < WIN_DEPTH - 1; i++) begin
			if (win_q[i] != SEEN_BY[8*(WIN_DEPTH-1-i) +: 8]) begin
				six_eq = 1'b0;
			end
		end
	end

	assign stat.head      = win_q[0];
	assign stat.fill      = fill_q;
	assign stat.six_match = six_eq;
	assign stat.tail_y    = (win_q[WIN_DEPTH-1] == SEEN_BY[7:0]);

endmodule

FILE: hw/rtl/cls_classify.sv
// ----------------------------------------------------------------------------
// cls_classify
// Decides what the oldest window byte yields and how the line state moves.
// ----------------------------------------------------------------------------
module cls_classify
	import cls_pkg::*;
(
	input  logic       [7:0] head,
	input  logic             match,
	input  logic             at_start,
	input  logic             in_ctl,
	input  logic             keep,
	output cls_step_t        step
);

	logic eol;
	logic pfx;
	logic ctl;

	assign eol = (head == CHAR_CR) || (head == CHAR_LF);
	assign pfx = at_start && (head != CHAR_CTL) && match && keep;
	assign ctl = in_ctl || (at_start && ((head == CHAR_CTL) || match));

	// The inserted 0x01 is a step of its own that leaves the head in place.
	always_comb begin
		if (pfx) begin
			step.emit      = 1'b1;
			step.consume   = 1'b0;
			step.data      = CHAR_CTL;
			step.to_ctl    = 1'b1;
			step.nxt_ctl   = 1'b1;
			step.nxt_start = 1'b0;
		end else begin
			step.emit      = ctl ? (!eol && keep) : 1'b1;
			step.consume   = 1'b1;
			step.data      = head;
			step.to_ctl    = ctl;
			step.nxt_ctl   = ctl && !eol;
			step.nxt_start = eol;
		end
	end

endmodule

FILE: hw/rtl/cls_out_reg.sv
// ----------------------------------------------------------------------------
// cls_out_reg
// Result register that holds one result until its transfer completes.
// ----------------------------------------------------------------------------
module cls_out_reg
	import cls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  cls_res_t res,
	input  logic     out_stall,
	output logic     out_valid,
	output cls_res_t out_res,
	output logic     slot_free
);

	logic     valid_q;
	cls_res_t res_q;

	assign slot_free = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

FILE: hw/rtl/control_line_splitter.sv
// ----------------------------------------------------------------------------
// control_line_splitter
// Throughput is one byte per cycle while the output does not stall; a SEEN-BY
// line start with keep_control set takes a step of its own for the inserted 0x01.
// A byte's result enters the result register no sooner than six later bytes
// have arrived, unless its message ends first. The last byte of a message
// blocks input while the window drains, any inserted 0x01 is emitted and the
// end marker is sent, and longer while the output stalls. Asynchronous reset
// empties the window, clears the output and sets keep_control to 1.
// ----------------------------------------------------------------------------
`include "control_line_splitter_assert.svh"

module control_line_splitter
	import cls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       to_control,
	output logic       end_marker,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       keep_control
);

	logic          keep_q;
	logic          in_ctl_q;
	logic          at_start_q;
	logic          drain_q;

	cls_win_cmd_t  win_cmd;
	cls_win_stat_t win_stat;
	cls_step_t     step;
	cls_res_t      res;
	cls_res_t      out_res;

	logic          slot_free;
	logic          in_ok;
	logic          acc;
	logic          fill_full;
	logic          fill_last;
	logic          step_in;
	logic          step_req;
	logic          step_go;
	logic          end_go;
	logic          match;
	logic          load;

	assign fill_full = (win_stat.fill == FILL_FULL);
	assign fill_last = (win_stat.fill == FILL_LAST);

	assign in_ok    = !drain_q && !fill_full && (!fill_last || slot_free);
	assign in_stall = !in_ok;
	assign acc      = in_valid && in_ok;

	assign step_in  = acc && !last_byte && fill_last;
	assign step_req = step_in || (!drain_q && fill_full) ||
	                  (drain_q && (win_stat.fill != '0));

	assign match = win_stat.six_match &&
	               (step_in ? (data_byte == SEEN_BY[7:0]) : (fill_full && win_stat.tail_y));

	cls_classify u_classify (
		.head     (win_stat.head),
		.match    (match),
		.at_start (at_start_q),
		.in_ctl   (in_ctl_q),
		.keep     (keep_q),
		.step     (step)
	);

	assign step_go = step_req && (!step.emit || slot_free);
	assign end_go  = drain_q && (win_stat.fill == '0) && slot_free;

	assign win_cmd.push = acc;
	assign win_cmd.pop  = step_go && step.consume;

	cls_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (win_cmd),
		.data   (data_byte),
		.stat   (win_stat)
	);

	assign load = (step_go && step.emit) || end_go;

	always_comb begin
		if (end_go) begin
			res.data   = '0;
			res.to_ctl = 1'b0;
			res.endm   = 1'b1;
		end else begin
			res.data   = step.data;
			res.to_ctl = step.to_ctl;
			res.endm   = 1'b0;
		end
	end

	cls_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.slot_free (slot_free)
	);

	assign out_byte   = out_res.data;
	assign to_control = out_res.to_ctl;
	assign end_marker = out_res.endm;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			keep_q <= keep_control;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ctl_q   <= 1'b0;
			at_start_q <= 1'b1;
			drain_q    <= 1'b0;
		end else begin
			if (step_go) begin
				in_ctl_q   <= step.nxt_ctl;
				at_start_q <= step.nxt_start;
			end
			if (end_go) begin
				in_ctl_q   <= 1'b0;
				at_start_q <= 1'b1;
				drain_q    <= 1'b0;
			end
			if (acc && last_byte) begin
				drain_q <= 1'b1;
			end
		end
	end

	`CLS_ASSERT_NOW(a_full_after_prefix, fill_full && !drain_q, !at_start_q && in_ctl_q, "full window")
	`CLS_ASSERT_NEXT(a_last_starts_drain, acc && last_byte, drain_q && in_stall, "no drain")
	`CLS_ASSERT_NEXT(a_end_closes_drain, end_go, !drain_q && at_start_q && !in_ctl_q && end_marker, "bad end")

endmodule

FILE: bench/tb_control_line_splitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_control_line_splitter
// Feeds message text through the splitter and checks every routed byte and
// end marker against a model kept in the bench. A few hand-built messages
// cover the control line forms first. Random messages follow under both
// settings of keep_control, with stalls on either side.
// ----------------------------------------------------------------------------
module tb_control_line_splitter
	import cls_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       hold;
	} text_item_t;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte    = 8'h00;
	logic       last_byte    = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] out_byte;
	logic       to_control;
	logic       end_marker;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic       keep_control = 1'b1;

	control_line_splitter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.to_control   (to_control),
		.end_marker   (end_marker),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.keep_control (keep_control)
	);

	text_item_t text_q[$];
	cls_res_t   routed_q[$];

	logic [7:0] win[WIN_DEPTH];
	int         win_fill;
	bit         in_ctl_line;
	bit         at_start;
	bit         keep_ctl;

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_next;
	int  queued;
	int  cycle_count;
	int  errors;
	int  bytes_sent;
	int  results_seen;
	int  ctl_seen;
	int  ends_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void push_routed(logic [7:0] b, bit ctl, bit endm);
		cls_res_t r;
		r.data   = b;
		r.to_ctl = ctl;
		r.endm   = endm;
		routed_q.push_back(r);
	endfunction

	function automatic bit window_is_seen_by();
		if (win_fill < WIN_DEPTH)
			return 1'b0;
		for (int i = 0; i < WIN_DEPTH; i++)
			if (win[i] != SEEN_BY[8*(WIN_DEPTH-1-i) +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void retire_head();
		logic [7:0] b;
		bit         eol;
		b   = win[0];
		eol = (b == CHAR_CR) || (b == CHAR_LF);
		if (at_start && b == CHAR_CTL) begin
			in_ctl_line = 1'b1;
		end else if (at_start && window_is_seen_by()) begin
			in_ctl_line = 1'b1;
			if (keep_ctl)
				push_routed(CHAR_CTL, 1'b1, 1'b0);
		end
		if (in_ctl_line) begin
			if (!eol && keep_ctl)
				push_routed(b, 1'b1, 1'b0);
		end else begin
			push_routed(b, 1'b0, 1'b0);
		end
		at_start = eol;
		if (eol)
			in_ctl_line = 1'b0;
		for (int i = 0; i < WIN_DEPTH - 1; i++)
			win[i] = win[i+1];
		win[WIN_DEPTH-1] = 8'h00;
		if (win_fill > 0)
			win_fill--;
	endfunction

	function automatic void route_byte(logic [7:0] b, bit last);
		if (win_fill >= WIN_DEPTH)
			retire_head();
		win[win_fill] = b;
		win_fill++;
		if (last) begin
			while (win_fill > 0)
				retire_head();
			push_routed(8'h00, 1'b0, 1'b1);
			in_ctl_line = 1'b0;
			at_start    = 1'b1;
		end else if (win_fill >= WIN_DEPTH) begin
			retire_head();
		end
	endfunction

	function automatic void check_result();
		cls_res_t want;
		bit       bad;
		results_seen++;
		if (routed_q.size() == 0) begin
			if (errors < 10)
				$display("unexpected result: byte %02h ctl %0b end %0b",
					out_byte, to_control, end_marker);
			errors++;
			return;
		end
		want = routed_q.pop_front();
		bad  = (to_control !== want.to_ctl) || (end_marker !== want.endm) ||
			(!want.endm && out_byte !== want.data);
		if (bad) begin
			if (errors < 10)
				$display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
					want.data, want.to_ctl, want.endm, out_byte, to_control, end_marker);
			errors++;
		end
		if (want.to_ctl)
			ctl_seen++;
		if (want.endm)
			ends_seen++;
	endfunction

	// Driver: a transfer holds its payload until accepted; a held item waits for
	// all outstanding results before it is offered.
	bit         drv_busy;
	text_item_t drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			drv_busy = in_valid;
			if (in_valid && !in_stall) begin
				route_byte(data_byte, last_byte);
				bytes_sent++;
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (text_q.size() > 0 && !(text_q[0].hold && routed_q.size() > 0) &&
						$urandom_range(99) >= send_idle_pct) begin
					drv_item = text_q.pop_front();
					in_valid  <= 1'b1;
					data_byte <= drv_item.data;
					last_byte <= drv_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("tb_control_line_splitter failed");
		$finish;
	end

	task automatic push_text(logic [7:0] b, bit last);
		text_item_t it;
		it.data   = b;
		it.last   = last;
		it.hold   = hold_next;
		hold_next = 1'b0;
		text_q.push_back(it);
		queued++;
	endtask

	task automatic push_seen_by(int n);
		for (int i = 0; i < n; i++)
			push_text(SEEN_BY[8*(WIN_DEPTH-1-i) +: 8], 1'b0);
	endtask

	task automatic add_message(bit finish);
		int kind;
		int len;
		int lines;
		if ($urandom_range(7) == 0) begin
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++)
				push_text(8'($urandom_range(1, 255)), 1'b0);
		end else begin
			lines = $urandom_range(1, 4);
			for (int l = 0; l < lines; l++) begin
				kind = $urandom_range(9);
				if (kind < 3) begin
					push_text(CHAR_CTL, 1'b0);
				end else if (kind < 6) begin
					push_seen_by(WIN_DEPTH);
				end else if (kind == 6) begin
					push_seen_by(WIN_DEPTH - 1);
					push_text("y", 1'b0);
				end
				len = $urandom_range(0, 12);
				for (int i = 0; i < len; i++)
					push_text(($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) :
						8'($urandom_range(32, 126)), 1'b0);
				case ($urandom_range(3))
					0: push_text(CHAR_LF, 1'b0);
					1: begin
						push_text(CHAR_CR, 1'b0);
						push_text(CHAR_LF, 1'b0);
					end
					2: push_text(CHAR_CR, 1'b0);
					default: ;
				endcase
			end
		end
		if (finish)
			push_text(8'($urandom_range(1, 255)), 1'b1);
	endtask

	// Halfway through each batch the sender waits once for every pending result.
	task automatic fill_random(int target, bit close);
		bit held;
		held = 1'b0;
		@(negedge clk);
		queued = 0;
		while (queued < target) begin
			if (!held && queued > target / 2) begin
				hold_next = 1'b1;
				held      = 1'b1;
			end
			add_message(1'b1);
		end
		if (!close)
			add_message(1'b0);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (text_q.size() > 0 || in_valid || routed_q.size() > 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_keep(bit v);
		cfg_valid    <= 1'b1;
		keep_control <= v;
		do @(posedge clk);
		while (!cfg_ready);
		keep_ctl = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		for (int i = 0; i < WIN_DEPTH; i++)
			win[i] = 8'h00;
		win_fill      = 0;
		in_ctl_line   = 1'b0;
		at_start      = 1'b1;
		keep_ctl      = 1'b1;
		send_idle_pct = 8;
		recv_idle_pct = 60;
		hold_next     = 1'b0;
		errors        = 0;
		bytes_sent    = 0;
		results_seen  = 0;
		ctl_seen      = 0;
		ends_seen     = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Hand-built message: both control line forms, a zero byte, all ones, and
		// a SEEN-BY prefix cut short by the end of the message.
		@(negedge clk);
		push_text(CHAR_CTL, 1'b0);
		push_text("X", 1'b0);
		push_text(CHAR_CR, 1'b0);
		push_seen_by(WIN_DEPTH);
		push_text("!", 1'b0);
		push_text(CHAR_LF, 1'b0);
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b0);
		for (int i = 0; i < WIN_DEPTH - 1; i++)
			push_text(SEEN_BY[8*(WIN_DEPTH-1-i) +: 8], i == WIN_DEPTH - 2);
		wait_idle();

		// With control output off, the control line disappears entirely.
		@(posedge clk);
		write_keep(1'b0);
		@(negedge clk);
		push_text(CHAR_CTL, 1'b0);
		push_text("Q", 1'b0);
		push_text(CHAR_LF, 1'b0);
		push_text("Z", 1'b1);
		wait_idle();

		fill_random(85, 1'b1);
		wait_idle();

		send_idle_pct = 60;
		recv_idle_pct = 8;
		write_keep(1'b1);
		// This phase leaves a partial line in the window for the next setting.
		fill_random(85, 1'b0);
		wait_idle();

		write_keep(1'b0);
		fill_random(80, 1'b1);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_keep(1'b1);
		fill_random(85, 1'b1);
		wait_idle();

		$display("sent %0d text bytes, checked %0d results", bytes_sent, results_seen);
		$display("of which %0d control bytes and %0d end markers", ctl_seen, ends_seen);
		if (errors == 0) begin
			$display("tb_control_line_splitter passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb_control_line_splitter failed");
		end
		$finish;
	end

endmodule
